// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Bodies vanish when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/tcf_pkg.sv =====
`default_nettype none
package tcf_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned ANGLE_W     = 17;
  localparam int unsigned ACC_W       = 18;
  localparam int unsigned DUTY_W      = 8;
  localparam int unsigned S_DATA_W    = 96;
  localparam int unsigned M_DATA_W    = 64;
  localparam int unsigned DIV_W       = 42;
  localparam int unsigned QUO_W       = 24;
  localparam int unsigned DIV_CNT_W   = 5;
  localparam int unsigned TAB_IDX_W   = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CTRL_W      = 34;
  localparam int unsigned DNUM_W      = 12;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 17'sd46080;
  localparam logic signed [ACC_W-1:0]   HALF_TURN   = 18'sd23040;

  // Register reset values.
  localparam logic [15:0] BLEND_RST = 16'd49676;
  localparam logic [15:0] TSTEP_RST = 16'd10925;
  localparam logic [15:0] GAIN_RST  = 16'd256;
  localparam logic [15:0] SCALE_RST = 16'd131;

  // Duty window on the control value (1/32768 degree) and duty formula terms.
  // The offset is 180 degrees plus the whole part of the bias term; the
  // fractional part of the bias never carries into the quotient. The duty is
  // then the offset control over 1408, taken as a shift by 7 and a
  // reciprocal multiply for the division by 11.
  localparam logic signed [CTRL_W-1:0] WIN_LO      = -34'sd5852364;
  localparam logic signed [CTRL_W-1:0] WIN_HI      = -34'sd5636096;
  localparam logic signed [CTRL_W-1:0] DUTY_OFFSET = 34'sd5924454;
  localparam logic [12:0]              DUTY_RECIP  = 13'd5958;

  localparam logic [DIV_CNT_W-1:0] GYRO_DIV_STEPS = 5'd24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLEND = 2'd0,
    CFG_TSTEP = 2'd1,
    CFG_GAIN  = 2'd2,
    CFG_SCALE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic  in_load;
    axis_e axis;
    logic  axis_start;
    logic  div_gyro;
    logic  blend_mul1;
    logic  blend_mul2;
    logic  blend_write;
    logic  ctrl_mul;
    logic  duty_num;
    logic  duty_write;
    logic  out_load;
  } tcf_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic cor_busy;
    logic in_window;
    logic out_busy;
  } tcf_sts_t;

  // Arctangent of 2^-i in 1/65536 degree.
  function automatic logic [22:0] cordic_atan(input logic [TAB_IDX_W-1:0] idx);
    logic [22:0] v;
    case (idx)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117304;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      5'd18: v = 23'd14;
      5'd19: v = 23'd7;
      5'd20: v = 23'd4;
      5'd21: v = 23'd2;
      5'd22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tcf_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle, divisor pre-shifted by the caller.
module tcf_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire logic [tcf_pkg::DIV_W-1:0]       rem_i,
  input  wire logic [tcf_pkg::DIV_W-1:0]       dsr_i,
  input  wire logic [tcf_pkg::DIV_CNT_W-1:0]   steps_i,
  output logic                                 busy_o,
  output logic [tcf_pkg::QUO_W-1:0]            quo_o
);
  import tcf_pkg::*;

  logic [DIV_W-1:0]     rem_q, dsr_q, diff;
  logic [QUO_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 ge;

  // Trial subtraction of the current divisor weight.
  assign ge     = rem_q >= dsr_q;
  assign diff   = rem_q - dsr_q;
  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= steps_i;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Remainder, divisor and quotient.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= rem_i;
      dsr_q <= dsr_i;
      quo_q <= '0;
    end else if (busy_o) begin
      if (ge) begin
        rem_q <= diff;
      end
      quo_q <= {quo_q[QUO_W-2:0], ge};
      dsr_q <= dsr_q >> 1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tcf_cordic.sv =====
`default_nettype none
// Vectoring CORDIC atan2, one rotation per cycle, result in 1/128 degree.
module tcf_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  load_i,
  input  wire logic signed [tcf_pkg::SAMPLE_W-1:0]   y_i,
  input  wire logic signed [tcf_pkg::SAMPLE_W-1:0]   x_i,
  output logic                                       busy_o,
  output logic signed [tcf_pkg::ACC_W-1:0]           angle_o
);
  import tcf_pkg::*;

  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic signed [19:0]        x_q, y_q, xe, ye, xs, ys;
  logic signed [24:0]        z_q, zr, tab;
  logic signed [ACC_W-1:0]   base_q;
  logic [TAB_IDX_W-1:0]      idx_q;
  logic [CNT_W-1:0]          cnt_q;

  assign xe     = {{4{x_i[SAMPLE_W-1]}}, x_i};
  assign ye     = {{4{y_i[SAMPLE_W-1]}}, y_i};
  assign xs     = x_q >>> idx_q;
  assign ys     = y_q >>> idx_q;
  assign tab    = $signed({2'b00, cordic_atan(idx_q)});
  assign busy_o = cnt_q != '0;

  // Round the 1/65536 degree angle half up to 1/128 degree.
  assign zr      = z_q + 25'sd256;
  assign angle_o = base_q + $signed({{2{zr[24]}}, zr[24:9]});

  // Iteration counter; a zero y needs no rotation at all.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= (y_i == '0) ? '0 : CNT_W'(STEPS);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Rotation datapath with half-turn pre-rotation for negative x.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      idx_q <= '0;
      z_q   <= '0;
      if (y_i == '0) begin
        base_q <= x_i[SAMPLE_W-1] ? HALF_TURN : '0;
        x_q    <= xe;
        y_q    <= ye;
      end else if (x_i[SAMPLE_W-1]) begin
        base_q <= y_i[SAMPLE_W-1] ? -HALF_TURN : HALF_TURN;
        x_q    <= -xe;
        y_q    <= -ye;
      end else begin
        base_q <= '0;
        x_q    <= xe;
        y_q    <= ye;
      end
    end else if (busy_o) begin
      idx_q <= idx_q + 1'b1;
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + tab;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - tab;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/tcf_datapath.sv =====
`default_nettype none
`include "assert_macros.svh"
// Sample, angle and duty registers with the shared divider, CORDIC and multiplies.
module tcf_datapath #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tcf_pkg::tcf_cmd_t                   cmd_i,
  output tcf_pkg::tcf_sts_t                        sts_o,
  input  wire logic [tcf_pkg::S_DATA_W-1:0]        s_tdata_i,
  input  wire logic                                cfg_valid_i,
  input  wire logic [tcf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [15:0]                         cfg_data_i,
  input  wire logic                                m_tready_i,
  output logic                                     m_tvalid_o,
  output logic [tcf_pkg::M_DATA_W-1:0]             m_tdata_o,
  output logic                                     m_tuser_o
);
  import tcf_pkg::*;

  // Configuration registers.
  logic [15:0] blend_q, tstep_q, gain_q, scale_q, scale_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q <= BLEND_RST;
      tstep_q <= TSTEP_RST;
      gain_q  <= GAIN_RST;
      scale_q <= SCALE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BLEND: blend_q <= cfg_data_i;
        CFG_TSTEP: tstep_q <= cfg_data_i;
        CFG_GAIN:  gain_q  <= cfg_data_i;
        CFG_SCALE: scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign scale_eff = (scale_q == '0) ? 16'd1 : scale_q;

  // Input sample.
  logic [S_DATA_W-1:0] in_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      in_q <= s_tdata_i;
    end
  end

  // Per-axis operand selection.
  logic signed [SAMPLE_W-1:0] cor_y, cor_x, gyro;
  logic signed [ANGLE_W-1:0]  ang_x_q, ang_y_q, ang_z_q, ang;

  always_comb begin
    case (cmd_i.axis)
      AXIS_X: begin
        cor_y = in_q[31:16];
        cor_x = in_q[47:32];
        gyro  = in_q[63:48];
        ang   = ang_x_q;
      end
      AXIS_Y: begin
        cor_y = in_q[15:0];
        cor_x = in_q[47:32];
        gyro  = in_q[79:64];
        ang   = ang_y_q;
      end
      AXIS_Z: begin
        cor_y = in_q[15:0];
        cor_x = in_q[31:16];
        gyro  = in_q[95:80];
        ang   = ang_z_q;
      end
      default: begin
        cor_y = '0;
        cor_x = '0;
        gyro  = '0;
        ang   = '0;
      end
    endcase
  end

  // Gyro magnitude times the time step.
  logic [16:0] gext, gabs;
  logic [32:0] gprod_q;
  logic        gsign_q;

  assign gext = {gyro[SAMPLE_W-1], gyro};
  assign gabs = gext[16] ? 17'(-gext) : gext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.axis_start) begin
      gsign_q <= gyro[SAMPLE_W-1];
      gprod_q <= 33'(gabs) * 33'(tstep_q);
    end
  end

  // Divider for the gyro scaling.
  logic                 div_busy;
  logic [QUO_W-1:0]     quo;
  logic [DIV_W-1:0]     div_rem, div_dsr;

  assign div_rem = {18'b0, gprod_q[32:9]};
  assign div_dsr = {3'b0, scale_eff, 23'b0};

  tcf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (cmd_i.div_gyro),
    .rem_i   (div_rem),
    .dsr_i   (div_dsr),
    .steps_i (GYRO_DIV_STEPS),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // Accelerometer angle.
  logic                    cor_busy;
  logic signed [ACC_W-1:0] acc_ang;

  tcf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (cmd_i.axis_start),
    .y_i     (cor_y),
    .x_i     (cor_x),
    .busy_o  (cor_busy),
    .angle_o (acc_ang)
  );

  // Complementary blend: first product, second product, then the saturated write.
  logic signed [24:0] gterm;
  logic signed [25:0] ang_plus;
  logic signed [42:0] a_s, ap_s, m1_q;
  logic [16:0]        abar;
  logic signed [35:0] abar_s, acc_s, m2_q;
  logic signed [43:0] bsum;
  logic signed [27:0] bres;
  logic signed [ANGLE_W-1:0] bsat;

  assign gterm    = gsign_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign ang_plus = 26'(ang) + 26'(gterm);
  assign a_s      = 43'($signed({1'b0, blend_q}));
  assign ap_s     = 43'(ang_plus);
  assign abar     = 17'(17'h10000 - {1'b0, blend_q});
  assign abar_s   = 36'($signed({1'b0, abar}));
  assign acc_s    = 36'(acc_ang);
  assign bsum     = 44'(m1_q) + 44'(m2_q) + 44'sd32768;
  assign bres     = bsum[43:16];

  always_comb begin
    if (bres > 28'sd46080) begin
      bsat = ANGLE_LIMIT;
    end else if (bres < -28'sd46080) begin
      bsat = -ANGLE_LIMIT;
    end else begin
      bsat = bres[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.blend_mul1) begin
      m1_q <= a_s * ap_s;
    end
    if (cmd_i.blend_mul2) begin
      m2_q <= abar_s * acc_s;
    end
  end

  // Filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_x_q <= '0;
      ang_y_q <= '0;
      ang_z_q <= '0;
    end else if (cmd_i.blend_write) begin
      case (cmd_i.axis)
        AXIS_X:  ang_x_q <= bsat;
        AXIS_Y:  ang_y_q <= bsat;
        AXIS_Z:  ang_z_q <= bsat;
        default: ;
      endcase
    end
  end

  // Control value, window test and duty numerator. Inside the window the
  // offset control stays below 2^19, so its bits above the factor of 128
  // fit in twelve bits.
  logic signed [CTRL_W-1:0] ctrl_q, shifted;
  logic                     in_window;
  logic [DNUM_W-1:0]        dnum_q;
  logic [24:0]              dprod;

  assign in_window = (ctrl_q >= WIN_LO) && (ctrl_q < WIN_HI);
  assign shifted   = ctrl_q + DUTY_OFFSET;
  assign dprod     = 25'(dnum_q) * 25'(DUTY_RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ctrl_mul) begin
      ctrl_q <= 34'(ang_x_q) * 34'($signed({1'b0, gain_q}));
    end
    if (cmd_i.duty_num) begin
      dnum_q <= shifted[18:7];
    end
  end

  // Held duty and update flag.
  logic [DUTY_W-1:0] duty_q;
  logic              written_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q    <= '0;
      written_q <= 1'b0;
    end else if (cmd_i.in_load) begin
      written_q <= 1'b0;
    end else if (cmd_i.duty_write) begin
      duty_q    <= dprod[24] ? 8'hFF : dprod[23:16];
      written_q <= 1'b1;
    end
  end

  // Output register.
  logic                tvalid_q;
  logic [M_DATA_W-1:0] tdata_q;
  logic                tuser_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      tdata_q <= {5'b0, duty_q, ang_z_q, ang_y_q, ang_x_q};
      tuser_q <= written_q;
    end
  end

  assign m_tvalid_o = tvalid_q;
  assign m_tdata_o  = tdata_q;
  assign m_tuser_o  = tuser_q;

  assign sts_o.div_busy  = div_busy;
  assign sts_o.cor_busy  = cor_busy;
  assign sts_o.in_window = in_window;
  assign sts_o.out_busy  = tvalid_q & ~m_tready_i;

  // A duty update only follows a control value inside the window.
  `ASSERT_IMPLIES(a_written_in_window, clk_i, rst_ni, written_q, in_window)
  // A new sample clears the update flag.
  `ASSERT_NEXT(a_load_clears_flag, clk_i, rst_ni, cmd_i.in_load, !written_q)
  // The X angle state never leaves its saturation range.
  `ASSERT_IMPLIES(a_angle_range, clk_i, rst_ni, 1'b1,
                  (ang_x_q <= ANGLE_LIMIT) && (ang_x_q >= -ANGLE_LIMIT))

endmodule
`default_nettype wire

// ===== sv/tcf_ctrl.sv =====
`default_nettype none
// Sequencer: three axes through divider, CORDIC and blend, then the duty path.
module tcf_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  output logic                     s_tready_o,
  input  wire tcf_pkg::tcf_sts_t   sts_i,
  output tcf_pkg::tcf_cmd_t        cmd_o
);
  import tcf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GMUL, ST_DLOAD, ST_ITER, ST_BMUL1, ST_BMUL2, ST_BWRITE,
    ST_CMUL, ST_WIN, ST_NUM, ST_DWRITE, ST_FIN
  } state_e;

  state_e state_q;
  axis_e  axis_q;

  assign s_tready_o = state_q == ST_IDLE;

  // State and axis register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= AXIS_X;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            state_q <= ST_GMUL;
            axis_q  <= AXIS_X;
          end
        end
        ST_GMUL:  state_q <= ST_DLOAD;
        ST_DLOAD: state_q <= ST_ITER;
        ST_ITER: begin
          if (!sts_i.div_busy && !sts_i.cor_busy) begin
            state_q <= ST_BMUL1;
          end
        end
        ST_BMUL1: state_q <= ST_BMUL2;
        ST_BMUL2: state_q <= ST_BWRITE;
        ST_BWRITE: begin
          case (axis_q)
            AXIS_X: begin
              axis_q  <= AXIS_Y;
              state_q <= ST_GMUL;
            end
            AXIS_Y: begin
              axis_q  <= AXIS_Z;
              state_q <= ST_GMUL;
            end
            default: state_q <= ST_CMUL;
          endcase
        end
        ST_CMUL:   state_q <= ST_WIN;
        ST_WIN:    state_q <= sts_i.in_window ? ST_NUM : ST_FIN;
        ST_NUM:    state_q <= ST_DWRITE;
        ST_DWRITE: state_q <= ST_FIN;
        ST_FIN: begin
          if (!sts_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Command decode.
  always_comb begin
    cmd_o             = '0;
    cmd_o.axis        = axis_q;
    cmd_o.in_load     = (state_q == ST_IDLE) && s_tvalid_i;
    cmd_o.axis_start  = state_q == ST_GMUL;
    cmd_o.div_gyro    = state_q == ST_DLOAD;
    cmd_o.blend_mul1  = state_q == ST_BMUL1;
    cmd_o.blend_mul2  = state_q == ST_BMUL2;
    cmd_o.blend_write = state_q == ST_BWRITE;
    cmd_o.ctrl_mul    = state_q == ST_CMUL;
    cmd_o.duty_num    = state_q == ST_NUM;
    cmd_o.duty_write  = state_q == ST_DWRITE;
    cmd_o.out_load    = (state_q == ST_FIN) && !sts_i.out_busy;
  end

endmodule
`default_nettype wire

// ===== sv/tilt_complementary_filter_thruster_pwm_core.sv =====
// Each accepted beat gives one result beat; the duty is recomputed only when the
// X angle falls in the duty window.
// A new sample is taken only after the last result is loaded for output, so a
// waiting result holds the input; each axis waits on the shared 24-step divider
// that scales the gyro rate, with the CORDIC running beside it.
// Reset: asynchronous, active low; angles and duty clear, registers take defaults.
`default_nettype none
module tilt_complementary_filter_thruster_pwm_core #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
  input  wire logic [tcf_pkg::S_DATA_W-1:0]      s_axis_tdata_i,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tilt_x, tilt_y, tilt_z (17 bits each), right_duty (8 bits), zero fill
  output logic [tcf_pkg::M_DATA_W-1:0]           m_axis_tdata_o,
  // duty_written
  output logic                                   m_axis_tuser_o,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [tcf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [15:0]                       cfg_data_i
);
  import tcf_pkg::*;

  tcf_cmd_t cmd;
  tcf_sts_t sts;

  // Registers are written whenever offered.
  assign cfg_ready_o = 1'b1;

  tcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcf_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_axis_tdata_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o)
  );

endmodule
`default_nettype wire

// ===== dv/tilt_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tilt_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [95:0] s_tdata_i,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [63:0] m_tdata_i,
  input  wire logic        m_tuser_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  import tcf_pkg::*;

  typedef struct packed {
    logic signed [16:0] tilt_x;
    logic signed [16:0] tilt_y;
    logic signed [16:0] tilt_z;
    logic [7:0]         duty;
    logic               written;
  } tilt_result_t;

  localparam int STEPS = 16;

  // Arctangent of 2^-i in 1/65536 degree, rows past 22 are zero.
  longint atan_lut [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0};

  longint weight_q, dt_q, kp_q, scale_q;
  longint ang_x, ang_y, ang_z, duty_q;
  tilt_result_t tilt_queue[$];

  // Arithmetic shift with floor rounding, as the hardware shifters do.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint accel_angle(longint y, longint x);
    longint base, z, xs, ys;
    base = 0;
    z = 0;
    if (y == 0) return (x < 0) ? 23040 : 0;
    if (x < 0) begin
      base = (y >= 0) ? 23040 : -23040;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z += atan_lut[i];
      end else begin
        x = x - ys; y = y + xs; z -= atan_lut[i];
      end
    end
    return base + floor_shift(z + 256, 9);
  endfunction

  function automatic longint fuse_angle(longint prev, longint rate, longint acc);
    longint cnt, gterm, total, r;
    cnt = (scale_q == 0) ? 1 : scale_q;
    // SystemVerilog division truncates toward zero, like the gyro divider.
    gterm = (rate * dt_q * 128) / (cnt * 65536);
    total = weight_q * (prev + gterm) + (65536 - weight_q) * acc;
    r = floor_shift(total + 32768, 16);
    if (r > 46080) r = 46080;
    if (r < -46080) r = -46080;
    return r;
  endfunction

  function automatic tilt_result_t predict_tilt(logic [95:0] d);
    longint ax, ay, az, ctrl, num, q;
    tilt_result_t res;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    ang_x = fuse_angle(ang_x, longint'($signed(d[63:48])), accel_angle(ay, az));
    ang_y = fuse_angle(ang_y, longint'($signed(d[79:64])), accel_angle(ax, az));
    ang_z = fuse_angle(ang_z, longint'($signed(d[95:80])), accel_angle(ax, ay));
    res.written = 1'b0;
    ctrl = ang_x * kp_q;
    if (ctrl < -5636096 && ctrl >= -5852364) begin
      num = (ctrl + 5898240) * 10000000 + 64'sd727272 * 360448;
      q = num / (64'sd1408 * 10000000);
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      duty_q = q;
      res.written = 1'b1;
    end
    res.tilt_x = ang_x[16:0];
    res.tilt_y = ang_y[16:0];
    res.tilt_z = ang_z[16:0];
    res.duty = duty_q[7:0];
    return res;
  endfunction

  assign pending_o = tilt_queue.size();

  // Track register writes, predict each input beat, compare each output beat.
  always @(posedge clk_i or negedge rst_ni) begin
    tilt_result_t want, got;
    if (!rst_ni) begin
      weight_q <= BLEND_RST; dt_q <= TSTEP_RST;
      kp_q <= GAIN_RST; scale_q <= SCALE_RST;
      ang_x = 0; ang_y = 0; ang_z = 0; duty_q = 0;
      tilt_queue.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_BLEND: weight_q = cfg_data_i;
          CFG_TSTEP: dt_q = cfg_data_i;
          CFG_GAIN:  kp_q = cfg_data_i;
          CFG_SCALE: scale_q = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) tilt_queue.push_back(predict_tilt(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got.tilt_x = m_tdata_i[16:0];
        got.tilt_y = m_tdata_i[33:17];
        got.tilt_z = m_tdata_i[50:34];
        got.duty = m_tdata_i[58:51];
        got.written = m_tuser_i;
        if (tilt_queue.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = tilt_queue.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import tcf_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk_i, rst_ni;
  logic [95:0] s_tdata;
  logic s_tvalid, s_tready;
  logic [63:0] m_tdata;
  logic m_tuser, m_tvalid, m_tready;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  int fail_count, pending, cycle_count;
  bit calm;

  tilt_complementary_filter_thruster_pwm_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tdata_i(s_tdata), .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  tilt_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tdata_i(s_tdata), .s_tvalid_i(s_tvalid), .s_tready_i(s_tready),
    .m_tdata_i(m_tdata), .m_tuser_i(m_tuser), .m_tvalid_i(m_tvalid),
    .m_tready_i(m_tready), .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver stalls at random except in calm stretches.
  always @(posedge clk_i) m_tready <= calm || ($urandom_range(99) >= 25);

  // Valid stays high after the beat; the next sample drops it.
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Valid drops only while idling, so beats can follow back to back.
  task automatic send_sample(logic [95:0] d);
    cfg_valid <= 1'b0;
    while (!calm && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tdata <= d;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Wait until every expected result has come, then let the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_field();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(signed'($urandom_range(400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  // Accelerometer set pointing the X angle near -175 degrees, to hit the duty window.
  function automatic logic [95:0] window_sample();
    logic [15:0] f [6];
    for (int k = 0; k < 6; k++) f[k] = pick_field();
    f[1] = 16'(-signed'($urandom_range(1500)));
    f[2] = 16'(-16000 - signed'($urandom_range(8000)));
    f[3] = 16'(signed'($urandom_range(200)) - 100);
    return {f[5], f[4], f[3], f[2], f[1], f[0]};
  endfunction

  function automatic logic [95:0] random_sample();
    logic [15:0] f [6];
    for (int k = 0; k < 6; k++) f[k] = pick_field();
    return {f[5], f[4], f[3], f[2], f[1], f[0]};
  endfunction

  initial begin
    logic [15:0] wt, dt, kp, sc;
    calm = 1'b1;
    rst_ni = 1'b0;
    s_tvalid = 1'b0; s_tdata = '0;
    cfg_valid = 1'b0; cfg_index = CFG_BLEND; cfg_data = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, zero y in atan2, then the duty window.
    send_sample('0);
    send_sample({6{16'h8000}});
    send_sample({6{16'h7fff}});
    send_sample({16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0100});
    send_sample({16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'hff00});
    send_sample({16'h7fff, 16'h8000, 16'h7fff, 16'h0, 16'h0, 16'h0});
    send_sample({16'h8000, 16'h7fff, 16'h8000, 16'hffff, 16'hffff, 16'hffff});
    for (int n = 0; n < 12; n++) send_sample(window_sample());
    drain();

    // Register extremes, including a zero gyro scale and full weight.
    write_reg(CFG_SCALE, 16'd0);
    write_reg(CFG_BLEND, 16'hffff);
    write_reg(CFG_TSTEP, 16'hffff);
    write_reg(CFG_GAIN, 16'hffff);
    for (int n = 0; n < 6; n++) send_sample(n[0] ? random_sample() : window_sample());
    drain();
    write_reg(CFG_BLEND, 16'd0);
    write_reg(CFG_TSTEP, 16'd0);
    write_reg(CFG_GAIN, 16'd0);
    write_reg(CFG_SCALE, 16'hffff);
    for (int n = 0; n < 4; n++) send_sample(window_sample());
    drain();

    // Random phases with varied settings; the fourth phase never idles or stalls.
    for (int ph = 0; ph < 8; ph++) begin
      wt = (ph == 0) ? BLEND_RST : 16'($urandom);
      dt = 16'($urandom);
      kp = (ph < 4) ? 16'($urandom_range(128, 512)) : 16'($urandom);
      sc = 16'($urandom_range(1, 400));
      write_reg(CFG_BLEND, wt);
      write_reg(CFG_TSTEP, dt);
      write_reg(CFG_GAIN, kp);
      write_reg(CFG_SCALE, sc);
      calm = (ph == 3);
      for (int n = 0; n < 250; n++)
        send_sample(($urandom_range(99) < 50) ? window_sample() : random_sample());
      calm = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
